### design/wfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants of the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

  // Default configuration handed to the top level.
  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // Fixed widths of the channel payloads.
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned REQNUM_W = 16;
  localparam int unsigned BLKNUM_W = 5;

  // Input item kinds.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fsm_e;

endpackage

### design/wfba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_in_if / wfba_out_if
// Valid/ready channels of the allocator: input items and result items.
// ----------------------------------------------------------------------------
interface wfba_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [wfba_pkg::SIZE_W-1:0]     size_value;

  modport source (output valid, output mode, output size_value, input ready);
  modport sink   (input valid, input mode, input size_value, output ready);
endinterface

interface wfba_out_if;
  logic                            valid;
  logic                            ready;
  logic [wfba_pkg::REQNUM_W-1:0]   request_number;
  logic                            granted;
  logic [wfba_pkg::BLKNUM_W-1:0]   block_number;
  logic [wfba_pkg::SIZE_W-1:0]     block_total;
  logic [wfba_pkg::SIZE_W-1:0]     leftover;

  modport source (output valid, output request_number, output granted,
                  output block_number, output block_total, output leftover,
                  input ready);
  modport sink   (input valid, input request_number, input granted,
                  input block_number, input block_total, input leftover,
                  output ready);
endinterface

### design/wfba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_cell
// One table slot: holds a block size with its taken and loaded flags, and
// updates the passing search token with a registered output.
// ----------------------------------------------------------------------------
module wfba_cell #(
  parameter int unsigned SIZE_BITS = wfba_pkg::SIZE_BITS_DEF,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_valid_i,
  input  logic                 tok_found_i,
  input  logic [IDX_W-1:0]     tok_idx_i,
  input  logic [SIZE_BITS-1:0] tok_size_i,
  output logic                 tok_valid_o,
  output logic                 tok_found_o,
  output logic [IDX_W-1:0]     tok_idx_o,
  output logic [SIZE_BITS-1:0] tok_size_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [SIZE_BITS-1:0] wr_data_i,
  input  logic                 take_en_i,
  input  logic [IDX_W-1:0]     take_idx_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                 loaded_q, loaded_d;
  logic                 taken_q, taken_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 valid_q;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic                 wins;

  always_comb begin
    loaded_d = loaded_q;
    taken_d  = taken_q;
    size_d   = size_q;
    if (wr_en_i && (wr_idx_i == MY_IDX)) begin
      loaded_d = 1'b1;
      taken_d  = 1'b0;
      size_d   = wr_data_i;
    end else if (take_en_i && (take_idx_i == MY_IDX)) begin
      taken_d = 1'b1;
    end
  end

  // Strict compare keeps the earlier block when sizes tie.
  assign wins = loaded_q && !taken_q && (!tok_found_i || (size_q > tok_size_i));

  always_comb begin
    found_d = tok_found_i;
    idx_d   = tok_idx_i;
    best_d  = tok_size_i;
    if (wins) begin
      found_d = 1'b1;
      idx_d   = MY_IDX;
      best_d  = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      taken_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      taken_q  <= taken_d;
      valid_q  <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    found_q <= found_d;
    idx_q   <= idx_d;
    best_q  <= best_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_found_o = found_q;
  assign tok_idx_o   = idx_q;
  assign tok_size_o  = best_q;

endmodule

### design/wfba_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_chain
// Row of table cells; the search token moves one cell per clock.
// ----------------------------------------------------------------------------
module wfba_chain #(
  parameter int unsigned MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 tail_valid_o,
  output logic                 tail_found_o,
  output logic [IDX_W-1:0]     tail_idx_o,
  output logic [SIZE_BITS-1:0] tail_size_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [SIZE_BITS-1:0] wr_data_i,
  input  logic                 take_en_i,
  input  logic [IDX_W-1:0]     take_idx_i
);

  logic                 tok_valid [MAX_BLOCKS+1];
  logic                 tok_found [MAX_BLOCKS+1];
  logic [IDX_W-1:0]     tok_idx   [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] tok_size  [MAX_BLOCKS+1];

  // A fresh token carries no candidate yet.
  assign tok_valid[0] = start_i;
  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;
  assign tok_size[0]  = '0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    wfba_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (tok_valid[k]),
      .tok_found_i (tok_found[k]),
      .tok_idx_i   (tok_idx[k]),
      .tok_size_i  (tok_size[k]),
      .tok_valid_o (tok_valid[k+1]),
      .tok_found_o (tok_found[k+1]),
      .tok_idx_o   (tok_idx[k+1]),
      .tok_size_o  (tok_size[k+1]),
      .wr_en_i     (wr_en_i),
      .wr_idx_i    (wr_idx_i),
      .wr_data_i   (wr_data_i),
      .take_en_i   (take_en_i),
      .take_idx_i  (take_idx_i)
    );
  end

  assign tail_valid_o = tok_valid[MAX_BLOCKS];
  assign tail_found_o = tok_found[MAX_BLOCKS];
  assign tail_idx_o   = tok_idx[MAX_BLOCKS];
  assign tail_size_o  = tok_size[MAX_BLOCKS];

endmodule

### design/worst_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Fixed-partition worst-fit allocator built as a row of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: mode 0 loads a block size into the next free slot
//   (ignored once MAX_BLOCKS slots are filled), mode 1 requests a process
//   size. out_o delivers one beat per request: running request number, grant
//   flag, 1-based block number, block size and leftover (zeros on refusal).
//   A load gives no beat. A request sends a search token down the cell row,
//   one cell per cycle; the token passes the cell registers, the tail result
//   is stored in the best-candidate register in the scan state, and the
//   output register is loaded in the finish state. in_i is not ready while
//   a request is in flight. The output register holds a beat until out_o is
//   ready; a finished search waits for it, and no item is taken meanwhile.
//   Reset empties the table, clears the request count and drops any
//   pending beat.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wfba_in_if.sink           in_i,
  wfba_out_if.source        out_o
);

  localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OUT_W  = wfba_pkg::SIZE_W;
  localparam int unsigned RN_W   = wfba_pkg::REQNUM_W;
  localparam int unsigned BN_W   = wfba_pkg::BLKNUM_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  wfba_pkg::fsm_e state_q, state_d;

  logic                 in_ready;
  logic                 in_fire;
  logic                 scan_start;
  logic                 finish_fire;
  logic                 load_en;
  logic [SIZE_BITS-1:0] in_val;

  logic [CNT_W-1:0]     cnt_q;
  logic [RN_W-1:0]      req_cnt_q;
  logic [SIZE_BITS-1:0] req_q;

  logic                 tail_valid;
  logic                 tail_found;
  logic [IDX_W-1:0]     tail_idx;
  logic [SIZE_BITS-1:0] tail_size;

  logic                 best_found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [SIZE_BITS-1:0] best_size_q;
  logic                 grant;
  logic [IDX_W:0]       blk_num;

  logic                 out_valid_q;
  logic [RN_W-1:0]      out_reqnum_q;
  logic                 out_granted_q;
  logic [BN_W-1:0]      out_blknum_q;
  logic [OUT_W-1:0]     out_total_q;
  logic [OUT_W-1:0]     out_left_q;

  assign in_val  = SIZE_BITS'(in_i.size_value);
  assign in_fire = in_i.valid && in_ready;
  assign load_en = in_fire && (in_i.mode == wfba_pkg::MODE_LOAD) && (cnt_q < CNT_MAX);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wfba_pkg::ST_IDLE: begin
        if (in_fire && (in_i.mode == wfba_pkg::MODE_REQUEST)) state_d = wfba_pkg::ST_SCAN;
      end
      wfba_pkg::ST_SCAN: begin
        if (tail_valid) state_d = wfba_pkg::ST_FINISH;
      end
      wfba_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) state_d = wfba_pkg::ST_IDLE;
      end
      default: state_d = wfba_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready    = 1'b0;
    scan_start  = 1'b0;
    finish_fire = 1'b0;
    case (state_q)
      wfba_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        scan_start = in_i.valid && (in_i.mode == wfba_pkg::MODE_REQUEST);
      end
      wfba_pkg::ST_SCAN: begin
      end
      wfba_pkg::ST_FINISH: begin
        finish_fire = !out_valid_q || out_o.ready;
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wfba_pkg::ST_IDLE;
      cnt_q     <= '0;
      req_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (load_en) cnt_q <= cnt_q + CNT_W'(1);
      if (scan_start) req_cnt_q <= req_cnt_q + RN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_start) req_q <= in_val;
    if ((state_q == wfba_pkg::ST_SCAN) && tail_valid) begin
      best_found_q <= tail_found;
      best_idx_q   <= tail_idx;
      best_size_q  <= tail_size;
    end
  end

  assign grant   = best_found_q && (best_size_q > req_q);
  assign blk_num = {1'b0, best_idx_q} + (IDX_W + 1)'(1);

  wfba_chain #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .tail_valid_o (tail_valid),
    .tail_found_o (tail_found),
    .tail_idx_o   (tail_idx),
    .tail_size_o  (tail_size),
    .wr_en_i      (load_en),
    .wr_idx_i     (cnt_q[IDX_W-1:0]),
    .wr_data_i    (in_val),
    .take_en_i    (finish_fire && grant),
    .take_idx_i   (best_idx_q)
  );

  // Output register: a beat stays until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      out_reqnum_q  <= req_cnt_q;
      out_granted_q <= grant;
      out_blknum_q  <= grant ? BN_W'(blk_num) : '0;
      out_total_q   <= grant ? OUT_W'(best_size_q) : '0;
      out_left_q    <= grant ? OUT_W'(best_size_q - req_q) : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.request_number = out_reqnum_q;
  assign out_o.granted        = out_granted_q;
  assign out_o.block_number   = out_blknum_q;
  assign out_o.block_total    = out_total_q;
  assign out_o.leftover       = out_left_q;

endmodule

### design/wfba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module wfba_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            in_mode_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            out_granted_i,
  input logic [wfba_pkg::BLKNUM_W-1:0]   out_block_number_i,
  input logic [wfba_pkg::SIZE_W-1:0]     out_block_total_i,
  input logic [wfba_pkg::SIZE_W-1:0]     out_leftover_i
);

  // A waiting beat is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A request keeps the input closed on the next cycle.
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == wfba_pkg::MODE_REQUEST) |=> !in_ready_i)
    else $error("input taken while a request is in flight");

  // A refusal carries zero fields.
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_granted_i |->
      (out_block_number_i == '0) && (out_block_total_i == '0) && (out_leftover_i == '0))
    else $error("refusal with nonzero fields");

  // A grant never leaves more than the block holds; a zero request keeps it all.
  a_grant_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_granted_i |->
      (out_block_number_i != '0) && (out_leftover_i <= out_block_total_i))
    else $error("grant with inconsistent block fields");

endmodule

bind worst_fit_block_allocator wfba_checker u_wfba_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_mode_i          (in_i.mode),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_granted_i      (out_o.granted),
  .out_block_number_i (out_o.block_number),
  .out_block_total_i  (out_o.block_total),
  .out_leftover_i     (out_o.leftover)
);
